FILE: rtl/atat_pkg.sv
// Shared types and constants for the aging track table.
package atat_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int KEY_W       = 64;
    localparam int CONF_W      = 16;
    localparam int SIG_W       = 8;
    localparam int TIME_W      = 40;
    localparam int STALE_W     = 32;
    localparam int COUNT_W     = 5;

    localparam logic [STALE_W-1:0] STALE_RESET = 32'd60000;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_PRUNE  = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]         key;
        logic [CONF_W-1:0]        conf;
        logic signed [SIG_W-1:0]  sig;
        logic [TIME_W-1:0]        tstamp;
    } t_entry;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic shift;     // cells below the tail take their right neighbor
        logic tail_new;  // the tail takes the item instead of the head
        logic load;      // the addressed cell takes the item
    } t_cell_op;

endpackage

FILE: rtl/aging_track_table.sv
// Aging track table: keyed track store with oldest-entry eviction and pruning.
// Per item the chain rotates one entry per cycle: a hit, an append or a prune passes the
// valid entries once, and a miss on a full table passes them and then the full table again;
// the result shows one cycle before the next item is taken, later if it must wait.
// A new item is taken while the previous result still waits in the output register.
// Reset (synchronous, active low) empties the table and sets the stale limit to 60000 ms.
module aging_track_table
    import atat_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Configuration write channel.
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [STALE_W-1:0]       i_cfg_data,
    // Input item channel.
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_cmd,
    input  logic [KEY_W-1:0]         i_track_key,
    input  logic [CONF_W-1:0]        i_confidence,
    input  logic signed [SIG_W-1:0]  i_signal_dbm,
    input  logic [TIME_W-1:0]        i_time_ms,
    // Result item channel.
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_recent_valid,
    output logic [KEY_W-1:0]         o_recent_key,
    output logic [CONF_W-1:0]        o_recent_confidence,
    output logic signed [SIG_W-1:0]  o_recent_signal_dbm,
    output logic [TIME_W-1:0]        o_recent_time_ms,
    output logic [COUNT_W-1:0]       o_entry_count,
    output logic                     o_replaced_oldest
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] FULL     = CW'(ENTRIES);
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    // The sequencer walks the chain: SCAN looks for the key (rewriting a hit in
    // place) and finds the oldest entry, EVICT rotates once more to overwrite the
    // oldest entry, PRUNE rotates the live segment and drops stale entries.
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_EVICT = 5'b00100,
        S_PRUNE = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state               r_state,    n_state;
    logic [CW-1:0]        r_cnt,      n_cnt;
    logic [CW-1:0]        r_seg,      n_seg;
    logic [CW-1:0]        r_step,     n_step;
    logic                 r_found,    n_found;
    logic                 r_evict,    n_evict;
    logic [IW-1:0]        r_old_idx,  n_old_idx;
    logic [TIME_W-1:0]    r_old_time, n_old_time;
    t_entry               r_best,     n_best;
    logic                 r_best_vld, n_best_vld;
    t_entry               r_item,     n_item;
    logic [STALE_W-1:0]   r_stale;

    logic                 r_out_valid;
    logic                 r_o_rvalid;
    t_entry               r_o_entry;
    logic [COUNT_W-1:0]   r_o_count;
    logic                 r_o_evict;

    t_cell_op             w_op;
    logic [IW-1:0]        w_idx;
    t_entry               w_cell [ENTRIES];
    t_entry               w_head;
    logic                 w_in_acc;
    logic                 w_out_free;
    logic                 w_hit;
    logic                 w_keep;
    logic [TIME_W-1:0]    w_age;
    logic                 w_upd_en;
    t_entry               w_upd_val;

    // ---------------------------------------------------------------------
    // Cell chain. Cell 0 is the head that the sequencer inspects each cycle.
    // ---------------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
            atat_cell #(
                .IW  (IW),
                .IDX (gi)
            ) u_cell (
                .i_clk   (i_clk),
                .i_op    (w_op),
                .i_idx   (w_idx),
                .i_item  (r_item),
                .i_head  (w_head),
                .i_right (w_cell[(gi < ENTRIES - 1) ? gi + 1 : gi]),
                .o_entry (w_cell[gi])
            );
        end
    endgenerate

    assign w_head = w_cell[0];

    // Handshakes. Configuration is always taken; the input channel is open
    // only between items, and the output register frees itself on a take.
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // An entry survives a prune when it lies ahead of the prune time or its
    // age does not exceed the stale limit.
    assign w_age  = r_item.tstamp - w_head.tstamp;
    assign w_keep = (w_head.tstamp > r_item.tstamp) || (w_age <= TIME_W'(r_stale));
    assign w_hit  = !r_found && (w_head.key == r_item.key);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_seg      = r_seg;
        n_step     = r_step;
        n_found    = r_found;
        n_evict    = r_evict;
        n_old_idx  = r_old_idx;
        n_old_time = r_old_time;
        n_best     = r_best;
        n_best_vld = r_best_vld;
        n_item     = r_item;
        w_op       = '0;
        w_idx      = '0;
        w_upd_en   = 1'b0;
        w_upd_val  = w_head;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_item.key    = i_track_key;
                    n_item.conf   = i_confidence;
                    n_item.sig    = i_signal_dbm;
                    n_item.tstamp = i_time_ms;
                    n_step        = '0;
                    n_seg         = r_cnt;
                    n_found       = 1'b0;
                    n_evict       = 1'b0;
                    n_best_vld    = 1'b0;
                    n_state       = (i_cmd == CMD_PRUNE) ? S_PRUNE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_step < r_cnt) begin
                    // Rotate the live entries once; a hit is replaced as it
                    // passes the tail, so the final values feed the newest search.
                    w_op.shift    = 1'b1;
                    w_op.tail_new = w_hit;
                    w_idx         = IW'(r_cnt - CW'(1));
                    w_upd_en      = 1'b1;
                    w_upd_val     = w_hit ? r_item : w_head;
                    if (w_hit) begin
                        n_found = 1'b1;
                    end
                    if ((r_step == '0) || (w_head.tstamp < r_old_time)) begin
                        n_old_idx  = IW'(r_step);
                        n_old_time = w_head.tstamp;
                    end
                    n_step = r_step + CW'(1);
                end else if (r_found) begin
                    n_state = S_DONE;
                end else if (r_cnt < FULL) begin
                    // Append behind the last live entry; it comes last in
                    // index order, so it only wins the newest search on a
                    // strictly later timestamp.
                    w_op.load = 1'b1;
                    w_idx     = IW'(r_cnt);
                    w_upd_en  = 1'b1;
                    w_upd_val = r_item;
                    n_cnt     = r_cnt + CW'(1);
                    n_state   = S_DONE;
                end else begin
                    n_step     = '0;
                    n_best_vld = 1'b0;
                    n_evict    = 1'b1;
                    n_state    = S_EVICT;
                end
            end
            S_EVICT: begin
                if (r_step < FULL) begin
                    w_op.shift    = 1'b1;
                    w_op.tail_new = (IW'(r_step) == r_old_idx);
                    w_idx         = LAST_IDX;
                    w_upd_en      = 1'b1;
                    w_upd_val     = w_op.tail_new ? r_item : w_head;
                    n_step        = r_step + CW'(1);
                end else begin
                    n_state = S_DONE;
                end
            end
            S_PRUNE: begin
                if (r_step < r_cnt) begin
                    // Unvisited entries sit at the front of the segment and
                    // survivors collect at its back; a dropped entry leaves
                    // the segment, which compacts the table in order.
                    w_op.shift = 1'b1;
                    w_idx      = IW'(r_seg - CW'(1));
                    w_upd_en   = w_keep;
                    if (!w_keep) begin
                        n_seg = r_seg - CW'(1);
                    end
                    n_step = r_step + CW'(1);
                end else begin
                    n_cnt   = r_seg;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_upd_en && (!r_best_vld || (w_upd_val.tstamp > r_best.tstamp))) begin
            n_best     = w_upd_val;
            n_best_vld = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_stale     <= STALE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_valid) begin
                r_stale <= i_cfg_data;
            end
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers and the result register.
    always_ff @(posedge i_clk) begin
        r_seg      <= n_seg;
        r_step     <= n_step;
        r_found    <= n_found;
        r_evict    <= n_evict;
        r_old_idx  <= n_old_idx;
        r_old_time <= n_old_time;
        r_best     <= n_best;
        r_best_vld <= n_best_vld;
        r_item     <= n_item;
        if ((r_state == S_DONE) && w_out_free) begin
            r_o_rvalid <= r_best_vld;
            r_o_entry  <= r_best_vld ? r_best : '0;
            r_o_count  <= COUNT_W'(r_cnt);
            r_o_evict  <= r_evict;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_recent_valid      = r_o_rvalid;
    assign o_recent_key        = r_o_entry.key;
    assign o_recent_confidence = r_o_entry.conf;
    assign o_recent_signal_dbm = r_o_entry.sig;
    assign o_recent_time_ms    = r_o_entry.tstamp;
    assign o_entry_count       = r_o_count;
    assign o_replaced_oldest   = r_o_evict;

endmodule

FILE: rtl/atat_cell.sv
// One storage cell of the track chain.
module atat_cell
    import atat_pkg::*;
#(
    parameter int IW  = 4,
    parameter int IDX = 0
) (
    input  logic          i_clk,
    input  t_cell_op      i_op,
    input  logic [IW-1:0] i_idx,
    input  t_entry        i_item,
    input  t_entry        i_head,
    input  t_entry        i_right,
    output t_entry        o_entry
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    t_entry r_entry;
    t_entry n_entry;

    // Below the tail the cell shifts toward the head; the tail cell closes
    // the ring with the head entry or with the new item.
    always_comb begin
        n_entry = r_entry;
        if (i_op.shift) begin
            if (MY_IDX < i_idx) begin
                n_entry = i_right;
            end else if (MY_IDX == i_idx) begin
                n_entry = i_op.tail_new ? i_item : i_head;
            end
        end else if (i_op.load && (MY_IDX == i_idx)) begin
            n_entry = i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

FILE: rtl/atat_checker.sv
// Port-level checker for the aging track table, bound to the top level.
module atat_checker
    import atat_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [KEY_W-1:0]   o_recent_key,
    input logic [COUNT_W-1:0] o_entry_count,
    input logic               o_replaced_oldest
);

    logic [1:0] r_pend;
    logic       w_in_acc;
    logic       w_out_acc;

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_out_acc = o_out_valid && !i_out_stall;

    // Items accepted whose results are not yet taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + {1'b0, w_in_acc} - {1'b0, w_out_acc};
        end
    end

    a_no_out_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result shown right after reset");

    a_out_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_pend != 2'd0))
        else $error("result without an accepted item");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3)
        else $error("more than two items outstanding");

    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_replaced_oldest) |-> (o_entry_count == COUNT_W'(ENTRIES)))
        else $error("eviction reported on a table that is not full");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_out_valid && i_out_stall) |-> (o_out_valid && $stable(o_recent_key)
            && $stable(o_entry_count)))
        else $error("stalled result changed");

endmodule

bind aging_track_table atat_checker #(.ENTRIES(ENTRIES)) u_atat_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_recent_key      (o_recent_key),
    .o_entry_count     (o_entry_count),
    .o_replaced_oldest (o_replaced_oldest)
);

FILE: bench/testbench.sv
// Self-checking testbench for the aging track table: random and directed items against a predictor.
`timescale 1ns / 100ps

module testbench;
    import atat_pkg::*;

    // One detection or prune request as it travels on the input channel.
    typedef struct packed {
        logic                    cmd;
        logic [KEY_W-1:0]        key;
        logic [CONF_W-1:0]       conf;
        logic signed [SIG_W-1:0] sig;
        logic [TIME_W-1:0]       time_ms;
    } det_item_t;

    // The report the block returns for every item: newest entry, count, eviction flag.
    typedef struct packed {
        logic                    valid;
        logic [KEY_W-1:0]        key;
        logic [CONF_W-1:0]       conf;
        logic signed [SIG_W-1:0] sig;
        logic [TIME_W-1:0]       time_ms;
        logic [COUNT_W-1:0]      count;
        logic                    evicted;
    } track_report_t;

    localparam int RUN_LIMIT   = 1000000;
    localparam int PHASE_ITEMS = 265;
    localparam int POOL_KEYS   = 20;
    localparam int DRAIN_WAIT  = 2 * ENTRIES_DEF + 8;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    // Configuration channel.
    logic               cfg_valid = 1'b0;
    logic [STALE_W-1:0] cfg_data  = '0;
    logic               cfg_ready;

    // Input channel: the payload register is held while the block stalls.
    logic      in_valid = 1'b0;
    det_item_t in_item  = '0;
    logic      in_stall;

    // Result channel.
    logic          out_valid;
    logic          out_stall = 1'b0;
    track_report_t got;

    // Idle behavior of both sides, in percent of cycles.
    int unsigned send_idle_pct  = 21;
    int unsigned recv_stall_pct = 61;

    det_item_t     pending_items[$];
    track_report_t report_q[$];
    int unsigned   queued_cnt   = 0;
    int unsigned   accepted_cnt = 0;
    int unsigned   fail_cnt     = 0;
    int unsigned   cycle_cnt    = 0;

    // Predictor state: its own copy of the table and of the stale limit.
    t_entry             trk[ENTRIES_DEF];
    int unsigned        trk_count   = 0;
    logic [STALE_W-1:0] stale_limit = STALE_RESET;

    aging_track_table u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (rst_n),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (cfg_ready),
        .i_cfg_data          (cfg_data),
        .i_in_valid          (in_valid),
        .o_in_stall          (in_stall),
        .i_cmd               (in_item.cmd),
        .i_track_key         (in_item.key),
        .i_confidence        (in_item.conf),
        .i_signal_dbm        (in_item.sig),
        .i_time_ms           (in_item.time_ms),
        .o_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .o_recent_valid      (got.valid),
        .o_recent_key        (got.key),
        .o_recent_confidence (got.conf),
        .o_recent_signal_dbm (got.sig),
        .o_recent_time_ms    (got.time_ms),
        .o_entry_count       (got.count),
        .o_replaced_oldest   (got.evicted)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Applies one item to the predicted table and returns the report it should produce.
    // A detection hits a matching key, else appends, else overwrites the entry with the
    // oldest timestamp (lowest index on a tie). A prune keeps entries whose age is within
    // the stale limit, or whose timestamp lies ahead of the prune time, in their order.
    function automatic track_report_t advance_track_table(input det_item_t it);
        track_report_t rep;
        int            slot;
        int            newest;
        int unsigned   kept;
        rep  = '0;
        slot = -1;
        if (it.cmd == CMD_UPDATE) begin
            for (int k = 0; k < trk_count; k++) begin
                if (slot < 0 && trk[k].key == it.key) slot = k;
            end
            if (slot < 0) begin
                if (trk_count < ENTRIES_DEF) begin
                    slot = trk_count;
                    trk_count++;
                end else begin
                    slot = 0;
                    for (int k = 1; k < ENTRIES_DEF; k++) begin
                        if (trk[k].tstamp < trk[slot].tstamp) slot = k;
                    end
                    rep.evicted = 1'b1;
                end
            end
            trk[slot].key    = it.key;
            trk[slot].conf   = it.conf;
            trk[slot].sig    = it.sig;
            trk[slot].tstamp = it.time_ms;
        end else begin
            kept = 0;
            for (int k = 0; k < trk_count; k++) begin
                if (trk[k].tstamp > it.time_ms ||
                    (it.time_ms - trk[k].tstamp) <= {8'd0, stale_limit}) begin
                    trk[kept] = trk[k];
                    kept++;
                end
            end
            trk_count = kept;
        end
        if (trk_count > 0) begin
            newest = 0;
            for (int k = 1; k < trk_count; k++) begin
                if (trk[k].tstamp > trk[newest].tstamp) newest = k;
            end
            rep.valid   = 1'b1;
            rep.key     = trk[newest].key;
            rep.conf    = trk[newest].conf;
            rep.sig     = trk[newest].sig;
            rep.time_ms = trk[newest].tstamp;
        end
        rep.count = trk_count[COUNT_W-1:0];
        return rep;
    endfunction

    // Driver. The item on the bus is taken at an edge where valid is high and the
    // block does not stall; its expected report is predicted right then, so the
    // predictor sees items in exactly the order the block does.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                report_q.push_back(advance_track_table(in_item));
                accepted_cnt++;
            end
            // A new item may be placed once the bus is free or its item was just taken.
            if (!in_valid || !in_stall) begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_item  <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string fname, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (got_v !== want_v) begin
            $error("%s mismatch: expected %0h, actual %0h", fname, want_v, got_v);
            fail_cnt++;
        end
    endtask

    // Monitor. Every report taken off the result channel is compared with the
    // oldest prediction; a report with nothing predicted is a failure on its own.
    always @(posedge i_clk) begin : monitor
        track_report_t want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (report_q.size() == 0) begin
                    $error("result item arrived with no expected item pending");
                    fail_cnt++;
                end else begin
                    want = report_q.pop_front();
                    check_field("recent_valid", 64'(want.valid), 64'(got.valid));
                    check_field("recent_key", want.key, got.key);
                    check_field("recent_confidence", 64'(want.conf), 64'(got.conf));
                    check_field("recent_signal_dbm", 64'(want.sig), 64'(got.sig));
                    check_field("recent_time_ms", 64'(want.time_ms), 64'(got.time_ms));
                    check_field("entry_count", 64'(want.count), 64'(got.count));
                    check_field("replaced_oldest", 64'(want.evicted), 64'(got.evicted));
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= RUN_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic void queue_item(input logic cmd, input logic [KEY_W-1:0] key,
                                       input logic [CONF_W-1:0] conf,
                                       input logic signed [SIG_W-1:0] sig,
                                       input logic [TIME_W-1:0] tms);
        det_item_t it;
        it.cmd     = cmd;
        it.key     = key;
        it.conf    = conf;
        it.sig     = sig;
        it.time_ms = tms;
        pending_items.push_back(it);
        queued_cnt++;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Waits until every queued item was taken and every predicted report has come back.
    task automatic wait_drained();
        while (accepted_cnt != queued_cnt || report_q.size() != 0) @(posedge i_clk);
    endtask

    // Writes the stale limit; the predictor takes the new value once the write lands.
    task automatic write_stale_limit(input logic [STALE_W-1:0] limit);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= limit;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        stale_limit = limit;
    endtask

    initial begin : stimulus
        logic [STALE_W-1:0] phase_limit[6];
        logic [KEY_W-1:0]   key_pool[POOL_KEYS];
        logic [63:0]        r;
        logic [TIME_W-1:0]  cursor;
        logic [TIME_W-1:0]  t;
        int unsigned        roll;

        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;

        // Directed part, under the reset stale limit of 60000 ms.
        // A prune of the empty table reports nothing valid and a zero count.
        queue_item(CMD_PRUNE, '0, '0, '0, '0);
        // Field extremes at both ends.
        queue_item(CMD_UPDATE, '0, '0, -8'sd128, '0);
        queue_item(CMD_UPDATE, '1, '1, 8'sd0, '1);
        // A hit on key zero, with a positive signal that is out of its nominal range.
        queue_item(CMD_UPDATE, '0, 16'd1, 8'sd127, 40'd5);
        // Two entries with the same timestamp; the all-ones timestamp stays the newest report.
        queue_item(CMD_UPDATE, 64'h0123_4567_89ab_cdef, 16'h8000, -8'sd40, 40'd100);
        queue_item(CMD_UPDATE, 64'hfedc_ba98_7654_3210, 16'h7fff, -8'sd41, 40'd100);
        // Prune where the all-ones timestamp and the ties lie ahead of the prune time.
        queue_item(CMD_PRUNE, rand64(), CONF_W'($urandom), SIG_W'($urandom), 40'd50);
        // Fill the table, then miss twice: first evicts the unique oldest, then the
        // lower of the two tied oldest entries.
        for (int k = 0; k < ENTRIES_DEF - 4; k++) begin
            queue_item(CMD_UPDATE, rand64(), CONF_W'($urandom), SIG_W'($urandom),
                       40'd200 + TIME_W'(k));
        end
        queue_item(CMD_UPDATE, rand64(), CONF_W'($urandom), SIG_W'($urandom), 40'd400);
        queue_item(CMD_UPDATE, rand64(), CONF_W'($urandom), SIG_W'($urandom), 40'd401);
        // Prune keeping everything, then one that drops all but the entry ahead in time,
        // then one at the largest time where that entry has an age of zero.
        queue_item(CMD_PRUNE, '0, '0, '0, 40'd300);
        queue_item(CMD_PRUNE, '1, '1, '1, 40'd1000000);
        queue_item(CMD_PRUNE, '0, '0, '0, '1);
        // Sender holds off here until the block has answered everything.
        wait_drained();

        phase_limit[0] = '0;
        phase_limit[1] = '1;
        phase_limit[2] = 32'd1500;
        phase_limit[3] = $urandom_range(1, 4000);
        phase_limit[4] = $urandom;
        phase_limit[5] = STALE_RESET;

        for (int p = 0; p < 6; p++) begin
            write_stale_limit(phase_limit[p]);
            // Sender idles lightly while the receiver stalls often, then the reverse,
            // then both run flat out.
            if (p < 2) begin
                send_idle_pct  = 21;
                recv_stall_pct = 61;
            end else if (p < 4) begin
                send_idle_pct  = 61;
                recv_stall_pct = 21;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end

            // A pool a little larger than the table keeps hits, appends and evictions
            // all frequent; time creeps forward from a random base, ties included.
            for (int k = 0; k < POOL_KEYS; k++) key_pool[k] = rand64();
            r      = rand64();
            cursor = r[TIME_W-1:0];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                roll   = $urandom_range(0, 99);
                cursor = cursor + TIME_W'($urandom_range(0, 40));
                if (roll < 3) begin
                    // Noise: any command, any timestamp.
                    r = rand64();
                    queue_item(1'($urandom_range(0, 1)), rand64(), CONF_W'($urandom),
                               SIG_W'($urandom), r[TIME_W-1:0]);
                end else if (roll < 12) begin
                    // Prune at the current time, now and then from a point in the past
                    // so that newer entries count as ahead of it.
                    t = ($urandom_range(0, 9) == 0) ? cursor - TIME_W'($urandom_range(0, 3000))
                                                    : cursor;
                    queue_item(CMD_PRUNE, rand64(), CONF_W'($urandom), SIG_W'($urandom), t);
                end else begin
                    t = ($urandom_range(0, 4) == 0) ? cursor - TIME_W'($urandom_range(0, 100))
                                                    : cursor;
                    queue_item(CMD_UPDATE,
                               ($urandom_range(0, 4) == 0) ? rand64()
                                                           : key_pool[$urandom_range(0, POOL_KEYS - 1)],
                               CONF_W'($urandom), SIG_W'($urandom), t);
                end
            end
            wait_drained();
        end

        // Anything the block sends after this point has no prediction and fails.
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
